// ===== src/satsc_pkg.sv =====
// ============================================================================
// satsc_pkg
// Shared types, codes and score arithmetic for the alignment tile scorer.
// ============================================================================
package satsc_pkg;

    // Default tile width in columns
    localparam int TILE_COLUMNS_DEF = 32;

    // Field widths
    localparam int SCORE_W   = 32;
    localparam int SUBST_W   = 7;
    localparam int RES_W     = 3;
    localparam int WIDTH_W   = 6;
    localparam int COL_W     = 5;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    // Register reset values
    localparam logic [WIDTH_W-1:0]        WIDTH_RST  = 6'd32;
    localparam logic signed [SUBST_W-1:0] MATCH_RST  = 7'sd2;
    localparam logic signed [SUBST_W-1:0] TRANS_RST  = -7'sd2;
    localparam logic signed [SUBST_W-1:0] TRANSV_RST = -7'sd4;
    localparam logic signed [SUBST_W-1:0] GAP_RST    = -7'sd1;

    // Saturation limits
    localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

    // Item operation codes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_CORNER = 2'd1,
        OP_ROW    = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    // Register indexes (byte address divided by four)
    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_MATCH  = 3'd1,
        REG_TRANS  = 3'd2,
        REG_TRANSV = 3'd3,
        REG_GAP    = 3'd4
    } reg_idx_t;

    // Residue codes
    localparam logic [RES_W-1:0] RES_GAP = 3'd0;
    localparam logic [RES_W-1:0] RES_A   = 3'd1;
    localparam logic [RES_W-1:0] RES_C   = 3'd2;
    localparam logic [RES_W-1:0] RES_G   = 3'd3;
    localparam logic [RES_W-1:0] RES_T   = 3'd4;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_RESULT,
        ST_READ
    } state_t;

    // Wavefront token passed from cell to cell
    typedef struct packed {
        logic                        valid;
        logic [RES_W-1:0]            residue;
        logic signed [SCORE_W-1:0]   left;
        logic signed [SCORE_W-1:0]   diag;
    } token_t;

    // Column load request to one cell
    typedef struct packed {
        logic                        en;
        logic [RES_W-1:0]            residue;
        logic signed [SCORE_W-1:0]   score;
    } load_t;

    // Scoring registers as seen by the cells
    typedef struct packed {
        logic signed [SUBST_W-1:0]   match_s;
        logic signed [SUBST_W-1:0]   trans_s;
        logic signed [SUBST_W-1:0]   transv_s;
        logic signed [SUBST_W-1:0]   gap_s;
    } scoring_t;

    // Saturating add of a small signed score to a 32-bit score
    function automatic logic signed [SCORE_W-1:0] sat_add(
        input logic signed [SCORE_W-1:0] a,
        input logic signed [SUBST_W-1:0] b
    );
        logic signed [SCORE_W:0] sum;
        sum = {a[SCORE_W-1], a} + {{(SCORE_W-SUBST_W+1){b[SUBST_W-1]}}, b};
        if (sum[SCORE_W] != sum[SCORE_W-1])
            return sum[SCORE_W] ? SCORE_MIN : SCORE_MAX;
        return sum[SCORE_W-1:0];
    endfunction

    // Substitution score of two residue codes
    function automatic logic signed [SUBST_W-1:0] subst(
        input logic [RES_W-1:0] a,
        input logic [RES_W-1:0] b,
        input scoring_t         sc
    );
        if (a == RES_GAP || a > RES_T || b == RES_GAP || b > RES_T)
            return sc.gap_s;
        if (a == b)
            return sc.match_s;
        if ((a == RES_A && b == RES_G) || (a == RES_G && b == RES_A) ||
            (a == RES_C && b == RES_T) || (a == RES_T && b == RES_C))
            return sc.trans_s;
        return sc.transv_s;
    endfunction

endpackage

// ===== src/satsc_cell.sv =====
// ============================================================================
// satsc_cell
// One tile column: holds the column residue and running score, scores the
// wavefront token when it arrives and hands it on to the next column.
// ============================================================================
module satsc_cell (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  satsc_pkg::token_t                       tok_in,
    input  satsc_pkg::load_t                        ld,
    input  satsc_pkg::scoring_t                     sc,
    output satsc_pkg::token_t                       tok_out,
    output logic signed [satsc_pkg::SCORE_W-1:0]    score
);

    logic [satsc_pkg::RES_W-1:0]            cell_res_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   cell_score_reg;
    logic                                   tok_valid_reg;
    logic [satsc_pkg::RES_W-1:0]            tok_res_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   tok_left_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   tok_diag_reg;

    logic signed [satsc_pkg::SCORE_W-1:0]   diag_term;
    logic signed [satsc_pkg::SCORE_W-1:0]   left_term;
    logic signed [satsc_pkg::SCORE_W-1:0]   top_term;
    logic signed [satsc_pkg::SCORE_W-1:0]   best_next;

    // Score this cell: best of diagonal, left and top moves
    always_comb
    begin
        diag_term = satsc_pkg::sat_add(tok_in.diag,
                        satsc_pkg::subst(tok_in.residue, cell_res_reg, sc));
        left_term = satsc_pkg::sat_add(tok_in.left, sc.gap_s);
        top_term  = satsc_pkg::sat_add(cell_score_reg, sc.gap_s);
        best_next = (left_term > top_term) ? left_term : top_term;
        if (diag_term > best_next)
            best_next = diag_term;
    end

    // Advance token valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_valid_reg <= 1'b0;
        else
            tok_valid_reg <= tok_in.valid;
    end

    // Update column state and hand the token on
    always_ff @(posedge clk)
    begin
        if (tok_in.valid)
        begin
            tok_res_reg    <= tok_in.residue;
            tok_left_reg   <= best_next;
            tok_diag_reg   <= cell_score_reg;
            cell_score_reg <= best_next;
        end
        else if (ld.en)
        begin
            cell_res_reg   <= ld.residue;
            cell_score_reg <= ld.score;
        end
    end

    assign tok_out.valid   = tok_valid_reg;
    assign tok_out.residue = tok_res_reg;
    assign tok_out.left    = tok_left_reg;
    assign tok_out.diag    = tok_diag_reg;
    assign score           = cell_score_reg;

endmodule

// ===== src/sequence_alignment_tile_scorer.sv =====
// ============================================================================
// sequence_alignment_tile_scorer
// Linear-gap global alignment scorer for one tile, built as a chain of
// column cells that a row wavefront sweeps from left to right.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) takes one item per handshake:
//   load column, set corner, process row or read bottom row. Output channel
//   (out_valid / out_stall) returns results: a row gives one right column
//   score, a readout gives one bottom row score per used column, column 0
//   first, with last set on the final one.
//   Load column and set corner leave the input ready. A row item enters
//   cell 0 on acceptance and moves one cell per cycle to the last used
//   column (W = used columns); its result then goes to the output register,
//   or is held aside while the output is stalled, and the next item is
//   taken once the result is held. A readout gives W results, one per
//   cycle while not stalled. No new row is taken while one is in the chain.
//   The output register holds its item while out_stall is high; the input
//   side keeps taking items while a result waits there.
//   Reset clears the control state and the registers to defaults. Column
//   residues and scores are undefined until loaded; no clearing pass. The
//   user must write configuration via APB port only while idle; unchecked.
// ============================================================================
module sequence_alignment_tile_scorer #(
    parameter int TILE_COLUMNS = satsc_pkg::TILE_COLUMNS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // configuration port
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [satsc_pkg::PADDR_W-1:0]           paddr,
    input  logic [satsc_pkg::PDATA_W-1:0]           pwdata,
    output logic [satsc_pkg::PDATA_W-1:0]           prdata,
    output logic                                    pready,
    // input channel
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic [1:0]                              op,
    input  logic [satsc_pkg::COL_W-1:0]             column_index,
    input  logic [satsc_pkg::RES_W-1:0]             residue,
    input  logic signed [satsc_pkg::SCORE_W-1:0]    halo_score,
    // output channel
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic                                    kind,
    output logic signed [satsc_pkg::SCORE_W-1:0]    score,
    output logic                                    last
);

    localparam int IDX_W = (TILE_COLUMNS > 1) ? $clog2(TILE_COLUMNS) : 1;
    localparam int CNT_W = 7;

    // Configuration registers
    logic [satsc_pkg::WIDTH_W-1:0]          width_reg;
    logic signed [satsc_pkg::SUBST_W-1:0]   match_reg;
    logic signed [satsc_pkg::SUBST_W-1:0]   trans_reg;
    logic signed [satsc_pkg::SUBST_W-1:0]   transv_reg;
    logic signed [satsc_pkg::SUBST_W-1:0]   gap_reg;
    satsc_pkg::reg_idx_t                    reg_idx;
    logic                                   cfg_wr;

    // Control
    satsc_pkg::state_t                      state_reg;
    satsc_pkg::state_t                      state_next;
    logic [IDX_W-1:0]                       rd_idx_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   prev_left_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   pend_score_reg;
    logic                                   in_acc;
    satsc_pkg::op_t                         op_code;
    logic [CNT_W-1:0]                       used_w;
    logic [CNT_W-1:0]                       w_m1_full;
    logic [IDX_W-1:0]                       w_m1;
    logic                                   out_free;
    logic                                   rd_last;

    // Output register
    logic                                   out_valid_reg;
    logic                                   kind_reg;
    logic signed [satsc_pkg::SCORE_W-1:0]   score_reg;
    logic                                   last_reg;
    logic                                   out_load;
    logic                                   kind_next;
    logic signed [satsc_pkg::SCORE_W-1:0]   score_next;
    logic                                   last_next;
    logic                                   pend_load;
    logic                                   rd_adv;

    // Column chain
    satsc_pkg::scoring_t                    sc;
    satsc_pkg::token_t                      tok_in_w  [TILE_COLUMNS];
    satsc_pkg::token_t                      tok_out_w [TILE_COLUMNS];
    satsc_pkg::load_t                       ld_w      [TILE_COLUMNS];
    logic signed [satsc_pkg::SCORE_W-1:0]   col_score [TILE_COLUMNS];
    logic [TILE_COLUMNS-1:0]                tok_vec;
    satsc_pkg::token_t                      end_tok;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_idx = satsc_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= satsc_pkg::WIDTH_RST;
            match_reg  <= satsc_pkg::MATCH_RST;
            trans_reg  <= satsc_pkg::TRANS_RST;
            transv_reg <= satsc_pkg::TRANSV_RST;
            gap_reg    <= satsc_pkg::GAP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                satsc_pkg::REG_WIDTH:  width_reg  <= pwdata[satsc_pkg::WIDTH_W-1:0];
                satsc_pkg::REG_MATCH:  match_reg  <= pwdata[satsc_pkg::SUBST_W-1:0];
                satsc_pkg::REG_TRANS:  trans_reg  <= pwdata[satsc_pkg::SUBST_W-1:0];
                satsc_pkg::REG_TRANSV: transv_reg <= pwdata[satsc_pkg::SUBST_W-1:0];
                satsc_pkg::REG_GAP:    gap_reg    <= pwdata[satsc_pkg::SUBST_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back registers
    always_comb
    begin
        unique case (reg_idx)
            satsc_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            satsc_pkg::REG_MATCH:  prdata = 32'($unsigned(match_reg));
            satsc_pkg::REG_TRANS:  prdata = 32'($unsigned(trans_reg));
            satsc_pkg::REG_TRANSV: prdata = 32'($unsigned(transv_reg));
            satsc_pkg::REG_GAP:    prdata = 32'($unsigned(gap_reg));
            default:               prdata = '0;
        endcase
    end

    assign sc.match_s  = match_reg;
    assign sc.trans_s  = trans_reg;
    assign sc.transv_s = transv_reg;
    assign sc.gap_s    = gap_reg;

    // Clamp the used width to 1..TILE_COLUMNS
    always_comb
    begin
        used_w = CNT_W'(width_reg);
        if (used_w == '0)
            used_w = CNT_W'(1);
        else if (used_w > CNT_W'(TILE_COLUMNS))
            used_w = CNT_W'(TILE_COLUMNS);
        w_m1_full = used_w - CNT_W'(1);
    end
    assign w_m1 = w_m1_full[IDX_W-1:0];

    // ------------------------------------------------------------------
    // Input handshake
    // ------------------------------------------------------------------
    assign in_stall = (state_reg != satsc_pkg::ST_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign op_code  = satsc_pkg::op_t'(op);

    // Hold the diagonal input of column 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prev_left_reg <= '0;
        else if (in_acc && (op_code == satsc_pkg::OP_CORNER || op_code == satsc_pkg::OP_ROW))
            prev_left_reg <= halo_score;
    end

    // ------------------------------------------------------------------
    // Column chain
    // ------------------------------------------------------------------
    assign tok_in_w[0].valid   = in_acc && (op_code == satsc_pkg::OP_ROW);
    assign tok_in_w[0].residue = residue;
    assign tok_in_w[0].left    = halo_score;
    assign tok_in_w[0].diag    = prev_left_reg;

    genvar k;
    generate
        for (k = 0; k < TILE_COLUMNS; k++)
        begin : g_col
            if (k > 0)
            begin : g_link
                // Drop the token after the last used column
                assign tok_in_w[k].valid   = tok_out_w[k-1].valid &&
                                             (w_m1 != IDX_W'(k-1));
                assign tok_in_w[k].residue = tok_out_w[k-1].residue;
                assign tok_in_w[k].left    = tok_out_w[k-1].left;
                assign tok_in_w[k].diag    = tok_out_w[k-1].diag;
            end

            assign ld_w[k].en      = in_acc && (op_code == satsc_pkg::OP_LOAD) &&
                                     (CNT_W'(column_index) == CNT_W'(k));
            assign ld_w[k].residue = residue;
            assign ld_w[k].score   = halo_score;
            assign tok_vec[k]      = tok_out_w[k].valid;

            satsc_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .tok_in  (tok_in_w[k]),
                .ld      (ld_w[k]),
                .sc      (sc),
                .tok_out (tok_out_w[k]),
                .score   (col_score[k])
            );
        end
    endgenerate

    assign end_tok  = tok_out_w[w_m1];
    assign out_free = !out_valid_reg || !out_stall;
    assign rd_last  = (rd_idx_reg == w_m1);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            satsc_pkg::ST_IDLE:
            begin
                if (in_acc && op_code == satsc_pkg::OP_ROW)
                    state_next = satsc_pkg::ST_ROW;
                else if (in_acc && op_code == satsc_pkg::OP_READ)
                    state_next = satsc_pkg::ST_READ;
            end
            satsc_pkg::ST_ROW:
            begin
                if (end_tok.valid)
                    state_next = out_free ? satsc_pkg::ST_IDLE : satsc_pkg::ST_RESULT;
            end
            satsc_pkg::ST_RESULT:
            begin
                if (out_free)
                    state_next = satsc_pkg::ST_IDLE;
            end
            satsc_pkg::ST_READ:
            begin
                if (out_free && rd_last)
                    state_next = satsc_pkg::ST_IDLE;
            end
            default: state_next = satsc_pkg::ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb
    begin
        out_load   = 1'b0;
        pend_load  = 1'b0;
        rd_adv     = 1'b0;
        kind_next  = 1'b0;
        score_next = end_tok.left;
        last_next  = 1'b0;
        unique case (state_reg)
            satsc_pkg::ST_IDLE: ;
            satsc_pkg::ST_ROW:
            begin
                if (end_tok.valid)
                begin
                    out_load  = out_free;
                    pend_load = !out_free;
                end
            end
            satsc_pkg::ST_RESULT:
            begin
                out_load   = out_free;
                score_next = pend_score_reg;
            end
            satsc_pkg::ST_READ:
            begin
                out_load   = out_free;
                rd_adv     = out_free;
                kind_next  = 1'b1;
                score_next = col_score[rd_idx_reg];
                last_next  = rd_last;
            end
            default: ;
        endcase
    end

    // Advance state and readout index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= satsc_pkg::ST_IDLE;
            rd_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc && op_code == satsc_pkg::OP_READ)
                rd_idx_reg <= '0;
            else if (rd_adv)
                rd_idx_reg <= rd_idx_reg + IDX_W'(1);
        end
    end

    // Hold a row result while the output is stalled
    always_ff @(posedge clk)
    begin
        if (pend_load)
            pend_score_reg <= end_tok.left;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg  <= kind_next;
            score_reg <= score_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign score     = score_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one row token in the column chain");

    a_token_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_vec != '0) |-> (state_reg == satsc_pkg::ST_ROW))
        else $error("row token present outside of row processing");

    a_read_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == satsc_pkg::ST_READ && out_load && rd_last)
        |=> (state_reg == satsc_pkg::ST_IDLE && out_valid_reg && last_reg))
        else $error("readout did not end on its last column");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("output register overwritten while stalled");

endmodule

// ===== tb/sv/sequence_alignment_tile_scorer_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// sequence_alignment_tile_scorer_tb
// Self-checking bench for the tile scorer. It fills all columns, runs a
// directed set of rows and readouts at reset scoring, then random phases
// under several register settings and idling patterns. Each accepted item
// is scored by a local wavefront model, and every output item is compared
// with the oldest expected score.
// ============================================================================
module sequence_alignment_tile_scorer_tb;

    localparam int COLUMNS       = satsc_pkg::TILE_COLUMNS_DEF;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = COLUMNS + 8;
    localparam int PHASE_ITEMS   = 38;

    typedef struct packed {
        satsc_pkg::op_t                       op;
        logic [satsc_pkg::COL_W-1:0]          col;
        logic [satsc_pkg::RES_W-1:0]          res;
        logic signed [satsc_pkg::SCORE_W-1:0] halo;
    } tile_item_t;

    typedef struct packed {
        logic                                 kind;
        logic signed [satsc_pkg::SCORE_W-1:0] score;
        logic                                 last;
    } tile_result_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 psel = 1'b0;
    logic                                 penable = 1'b0;
    logic                                 pwrite = 1'b0;
    logic [satsc_pkg::PADDR_W-1:0]        paddr = '0;
    logic [satsc_pkg::PDATA_W-1:0]        pwdata = '0;
    logic [satsc_pkg::PDATA_W-1:0]        prdata;
    logic                                 pready;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    logic [1:0]                           op = '0;
    logic [satsc_pkg::COL_W-1:0]          column_index = '0;
    logic [satsc_pkg::RES_W-1:0]          residue = '0;
    logic signed [satsc_pkg::SCORE_W-1:0] halo_score = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    logic                                 kind;
    logic signed [satsc_pkg::SCORE_W-1:0] score;
    logic                                 last;

    // Local copy of the tile and its scoring registers
    logic [satsc_pkg::RES_W-1:0]          tile_residue [COLUMNS];
    logic signed [satsc_pkg::SCORE_W-1:0] tile_score [COLUMNS];
    logic signed [satsc_pkg::SCORE_W-1:0] corner_score;
    logic [satsc_pkg::WIDTH_W-1:0]        cfg_width;
    logic signed [satsc_pkg::SUBST_W-1:0] cfg_match;
    logic signed [satsc_pkg::SUBST_W-1:0] cfg_trans;
    logic signed [satsc_pkg::SUBST_W-1:0] cfg_transv;
    logic signed [satsc_pkg::SUBST_W-1:0] cfg_gap;

    tile_item_t   pending_items [$];
    tile_result_t expected_scores [$];
    tile_item_t   next_item;
    tile_result_t want;

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  hold_arm = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;
    int  mismatches = 0;
    int  quiet_cycles = 0;

    sequence_alignment_tile_scorer i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .column_index (column_index),
        .residue      (residue),
        .halo_score   (halo_score),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .score        (score),
        .last         (last)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Clamp a wide sum to the signed score range
    function automatic logic signed [satsc_pkg::SCORE_W-1:0] sat_sum(input longint v);
        if (v > longint'(satsc_pkg::SCORE_MAX))
            return satsc_pkg::SCORE_MAX;
        if (v < longint'(satsc_pkg::SCORE_MIN))
            return satsc_pkg::SCORE_MIN;
        return v[satsc_pkg::SCORE_W-1:0];
    endfunction

    // Substitution score for a row residue against a column residue
    function automatic logic signed [satsc_pkg::SUBST_W-1:0] pair_score(
        input logic [satsc_pkg::RES_W-1:0] a,
        input logic [satsc_pkg::RES_W-1:0] b
    );
        bit a_base;
        bit b_base;
        a_base = (a >= satsc_pkg::RES_A) && (a <= satsc_pkg::RES_T);
        b_base = (b >= satsc_pkg::RES_A) && (b <= satsc_pkg::RES_T);
        if (!a_base || !b_base)
            return cfg_gap;
        if (a == b)
            return cfg_match;
        // purine pairs and pyrimidine pairs are transitions
        if ((a == satsc_pkg::RES_A && b == satsc_pkg::RES_G) ||
            (a == satsc_pkg::RES_G && b == satsc_pkg::RES_A) ||
            (a == satsc_pkg::RES_C && b == satsc_pkg::RES_T) ||
            (a == satsc_pkg::RES_T && b == satsc_pkg::RES_C))
            return cfg_trans;
        return cfg_transv;
    endfunction

    function automatic int used_columns();
        if (cfg_width == 0)
            return 1;
        if (cfg_width > COLUMNS)
            return COLUMNS;
        return int'(cfg_width);
    endfunction

    // Advance the local tile by one accepted item and queue its scores
    task automatic score_item(
        input satsc_pkg::op_t                       item_op,
        input logic [satsc_pkg::COL_W-1:0]          col,
        input logic [satsc_pkg::RES_W-1:0]          res,
        input logic signed [satsc_pkg::SCORE_W-1:0] halo
    );
        int     w;
        longint diag_in;
        longint cur;
        longint top_old;
        longint d;
        longint l;
        longint t;
        longint best;
        w = used_columns();
        case (item_op)
            satsc_pkg::OP_LOAD: begin
                tile_residue[col] = res;
                tile_score[col] = halo;
            end
            satsc_pkg::OP_CORNER: begin
                corner_score = halo;
            end
            satsc_pkg::OP_ROW: begin
                diag_in = corner_score;
                cur = halo;
                for (int k = 0; k < w; k++) begin
                    top_old = tile_score[k];
                    d = sat_sum(diag_in + pair_score(res, tile_residue[k]));
                    l = sat_sum(cur + cfg_gap);
                    t = sat_sum(top_old + cfg_gap);
                    best = (l > t) ? l : t;
                    if (d > best)
                        best = d;
                    diag_in = top_old;
                    tile_score[k] = best[satsc_pkg::SCORE_W-1:0];
                    cur = best;
                end
                corner_score = halo;
                expected_scores.push_back('{1'b0, cur[satsc_pkg::SCORE_W-1:0], 1'b0});
            end
            default: begin
                for (int k = 0; k < w; k++)
                    expected_scores.push_back('{1'b1, tile_score[k], k == w - 1});
            end
        endcase
    endtask

    // Offer pending items, hold the payload while stalled
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                score_item(satsc_pkg::op_t'(op), column_index, residue, halo_score);
            if (!in_valid || !in_stall) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_item = pending_items.pop_front();
                    in_valid <= 1'b1;
                    op <= next_item.op;
                    column_index <= next_item.col;
                    residue <= next_item.res;
                    halo_score <= next_item.halo;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Stall the output at random, once holding it off for a long stretch
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_arm && !hold_used) begin
            hold_used <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each output item with the oldest expected score
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_scores.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected output item: kind %0b score %0d last %0b",
                             kind, score, last);
                mismatches++;
            end else begin
                want = expected_scores.pop_front();
                if (kind !== want.kind || score !== want.score || last !== want.last) begin
                    if (mismatches < 10)
                        $display("mismatch: kind %0b/%0b score %0d/%0d last %0b/%0b (exp/act)",
                                 want.kind, kind, want.score, score, want.last, last);
                    mismatches++;
                end
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles == QUIET_LIMIT) begin
                    $display("sequence_alignment_tile_scorer regression: fail");
                    $finish;
                end
            end
        end
    end

    // Write one register through the APB port and mirror it
    task automatic write_reg(input satsc_pkg::reg_idx_t idx,
                             input logic [satsc_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            satsc_pkg::REG_WIDTH:  cfg_width = value[satsc_pkg::WIDTH_W-1:0];
            satsc_pkg::REG_MATCH:  cfg_match = value[satsc_pkg::SUBST_W-1:0];
            satsc_pkg::REG_TRANS:  cfg_trans = value[satsc_pkg::SUBST_W-1:0];
            satsc_pkg::REG_TRANSV: cfg_transv = value[satsc_pkg::SUBST_W-1:0];
            default:               cfg_gap = value[satsc_pkg::SUBST_W-1:0];
        endcase
    endtask

    task automatic apply_setting(input int w, input int m, input int tr, input int tv,
                                 input int g);
        @(negedge clk);
        write_reg(satsc_pkg::REG_WIDTH, 32'(w) & 32'h3F);
        write_reg(satsc_pkg::REG_MATCH, 32'(m) & 32'h7F);
        write_reg(satsc_pkg::REG_TRANS, 32'(tr) & 32'h7F);
        write_reg(satsc_pkg::REG_TRANSV, 32'(tv) & 32'h7F);
        write_reg(satsc_pkg::REG_GAP, 32'(g) & 32'h7F);
        @(negedge clk);
    endtask

    function automatic int random_subst();
        return int'($urandom_range(0, 127)) - 64;
    endfunction

    // Small scores, scores near both saturation limits and full-range random ones
    function automatic logic signed [satsc_pkg::SCORE_W-1:0] pick_score();
        case ($urandom_range(0, 4))
            0, 1:    return int'($urandom_range(0, 4000)) - 2000;
            2:       return satsc_pkg::SCORE_MAX - int'($urandom_range(0, 200));
            3:       return satsc_pkg::SCORE_MIN + int'($urandom_range(0, 200));
            default: return $urandom();
        endcase
    endfunction

    function automatic tile_item_t random_item();
        tile_item_t it;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 50)
            it.op = satsc_pkg::OP_ROW;
        else if (r < 62)
            it.op = satsc_pkg::OP_READ;
        else if (r < 85)
            it.op = satsc_pkg::OP_LOAD;
        else
            it.op = satsc_pkg::OP_CORNER;
        it.col = satsc_pkg::COL_W'($urandom_range(0, COLUMNS - 1));
        it.res = ($urandom_range(0, 3) == 0)
                 ? satsc_pkg::RES_W'($urandom_range(0, 7))
                 : satsc_pkg::RES_W'($urandom_range(satsc_pkg::RES_A, satsc_pkg::RES_T));
        it.halo = pick_score();
        return it;
    endfunction

    // Wait for every item and score to pass, then let the chain settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_scores.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic push_item(input satsc_pkg::op_t o, input int col, input int res,
                             input logic signed [satsc_pkg::SCORE_W-1:0] halo);
        pending_items.push_back('{o, satsc_pkg::COL_W'(col), satsc_pkg::RES_W'(res), halo});
    endtask

    initial begin
        corner_score = '0;
        cfg_width = satsc_pkg::WIDTH_RST;
        cfg_match = satsc_pkg::MATCH_RST;
        cfg_trans = satsc_pkg::TRANS_RST;
        cfg_transv = satsc_pkg::TRANSV_RST;
        cfg_gap = satsc_pkg::GAP_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Fill every column so no readout touches an unwritten entry
        for (int k = 0; k < COLUMNS; k++) begin
            if (k == 0 || k == COLUMNS - 1)
                push_item(satsc_pkg::OP_LOAD, k, k % 8, satsc_pkg::SCORE_MAX);
            else if (k == 1)
                push_item(satsc_pkg::OP_LOAD, k, k % 8, satsc_pkg::SCORE_MIN);
            else
                push_item(satsc_pkg::OP_LOAD, k, k % 8, k * 3 - 40);
        end

        // Directed rows and readouts at reset scoring
        push_item(satsc_pkg::OP_CORNER, 0, satsc_pkg::RES_GAP, satsc_pkg::SCORE_MIN);
        push_item(satsc_pkg::OP_ROW, 0, satsc_pkg::RES_A, satsc_pkg::SCORE_MAX);
        push_item(satsc_pkg::OP_ROW, 0, satsc_pkg::RES_T, satsc_pkg::SCORE_MIN);
        push_item(satsc_pkg::OP_ROW, 0, satsc_pkg::RES_GAP, 0);
        push_item(satsc_pkg::OP_ROW, 0, 7, -5);
        push_item(satsc_pkg::OP_READ, 0, satsc_pkg::RES_GAP, 0);
        push_item(satsc_pkg::OP_CORNER, 0, satsc_pkg::RES_GAP, 100);
        push_item(satsc_pkg::OP_ROW, 0, satsc_pkg::RES_G, 10);
        push_item(satsc_pkg::OP_ROW, 0, satsc_pkg::RES_C, -10);
        push_item(satsc_pkg::OP_LOAD, COLUMNS - 1, 6, satsc_pkg::SCORE_MIN);
        push_item(satsc_pkg::OP_ROW, 0, 5, 1);
        push_item(satsc_pkg::OP_READ, 0, satsc_pkg::RES_GAP, 0);
        drain();

        // Random phases over register extremes and idling patterns
        for (int phase = 1; phase <= 6; phase++) begin
            case (phase)
                1: begin
                    apply_setting(63, 63, -64, -64, 63);
                    send_idle_pct = 69;
                    stall_pct = 0;
                end
                2: begin
                    apply_setting(0, -64, 63, 0, -64);
                    send_idle_pct = 0;
                    stall_pct = 69;
                end
                3: begin
                    apply_setting(7, random_subst(), random_subst(), random_subst(),
                                  random_subst());
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
                4: begin
                    apply_setting(COLUMNS, random_subst(), random_subst(), random_subst(),
                                  random_subst());
                    send_idle_pct = 0;
                    stall_pct = 0;
                    hold_arm = 1'b1;
                end
                5: begin
                    apply_setting(33, -1, 0, 5, 1);
                    send_idle_pct = 35;
                    stall_pct = 35;
                end
                default: begin
                    apply_setting($urandom_range(1, COLUMNS), random_subst(),
                                  random_subst(), random_subst(), random_subst());
                    send_idle_pct = 69;
                    stall_pct = 69;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                pending_items.push_back(random_item());
            drain();
        end

        if (mismatches == 0)
            $display("sequence_alignment_tile_scorer regression: pass");
        else
            $display("sequence_alignment_tile_scorer regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
src/satsc_pkg.sv
src/satsc_cell.sv
src/sequence_alignment_tile_scorer.sv
tb/sv/sequence_alignment_tile_scorer_tb.sv
